@@ hw/rtl/bsws_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: shared definitions
// Sizes, command and status codes, and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsws_pkg;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CMP_W-1:0]         cmp_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam pos_t LAST_N = pos_t'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_UPDATE = 3'd4,
    CMD_DUMP   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_OVERFLOW  = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_BAD_INDEX = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;       // capture the search word
    logic    push_wr;     // write the request word on top, count up
    logic    upd_wr;      // overwrite the requested position
    logic    pop_dec;     // count down
    logic    rd_top;      // read the top entry
    logic    rd_first;    // start a scan at the bottom
    logic    rd_dump;     // start a dump at the top
    logic    scan_next;   // step the scan pointer up
    logic    dump_next;   // step the dump pointer down
    logic    res_set;     // load the pending result
    status_e res_status;
    logic    res_pos_ptr; // pending position comes from the scan pointer
    logic    out_load;    // load the output register
    logic    out_from_rd; // output data comes from the memory
    logic    out_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_ok;
    logic match;
    logic scan_last;
    logic dump_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/bsws_if.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: channel interfaces
// Request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsws_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            cmd;
  logic signed [31:0]    value;
  logic [2:0]            index;

  modport source (output valid, cmd, value, index, input ready);
  modport sink (input valid, cmd, value, index, output ready);
endinterface

interface bsws_out_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic signed [31:0]    data;
  logic [2:0]            position;
  logic                  last;

  modport source (output valid, status, data, position, last, input ready);
  modport sink (input valid, status, data, position, last, output ready);
endinterface

@@ hw/rtl/bsws_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module bsws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bsws_dp.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: datapath
// Entry memory, fill count, scan/dump pointer, pending result and the
// output register.
// ----------------------------------------------------------------------------
module bsws_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [31:0]     in_value_i,
  input  logic [2:0]             in_index_i,
  input  bsws_pkg::ctrl_cmd_t    cmd_i,
  output bsws_pkg::dp_sts_t      sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [2:0]             out_status_o,
  output logic signed [31:0]     out_data_o,
  output logic [2:0]             out_position_o,
  output logic                   out_last_o
);

  bsws_pkg::cnt_t    count_q, count_d;
  bsws_pkg::addr_t   ptr_q, ptr_d;
  bsws_pkg::pos_t    n_q, n_d;
  bsws_pkg::word_t   value_q;
  bsws_pkg::status_e res_status_q;
  bsws_pkg::pos_t    res_pos_q;
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  bsws_pkg::word_t   out_data_q;
  bsws_pkg::pos_t    out_pos_q;
  logic              out_last_q;

  bsws_pkg::addr_t   top_addr;
  bsws_pkg::addr_t   waddr;
  bsws_pkg::addr_t   raddr;
  logic              we;
  logic              re;
  logic [31:0]       rdata;

  assign top_addr = bsws_pkg::addr_t'(count_q - bsws_pkg::cnt_t'(1));

  always_comb begin
    we    = cmd_i.push_wr | cmd_i.upd_wr;
    waddr = cmd_i.upd_wr ? bsws_pkg::addr_t'(in_index_i)
                         : bsws_pkg::addr_t'(count_q);
    re    = cmd_i.rd_top | cmd_i.rd_first | cmd_i.rd_dump |
            cmd_i.scan_next | cmd_i.dump_next;
    raddr = top_addr;
    ptr_d = ptr_q;
    n_d   = n_q;
    if (cmd_i.rd_first) begin
      raddr = '0;
      ptr_d = '0;
    end else if (cmd_i.rd_dump) begin
      ptr_d = top_addr;
      n_d   = '0;
    end else if (cmd_i.scan_next) begin
      raddr = ptr_q + bsws_pkg::addr_t'(1);
      ptr_d = raddr;
    end else if (cmd_i.dump_next) begin
      raddr = ptr_q - bsws_pkg::addr_t'(1);
      ptr_d = raddr;
      n_d   = n_q + bsws_pkg::pos_t'(1);
    end
    count_d = count_q;
    if (cmd_i.push_wr) begin
      count_d = count_q + bsws_pkg::cnt_t'(1);
    end else if (cmd_i.pop_dec) begin
      count_d = count_q - bsws_pkg::cnt_t'(1);
    end
  end

  bsws_ram #(
    .WIDTH (bsws_pkg::WORD_W),
    .DEPTH (bsws_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    n_q   <= n_d;
    if (cmd_i.latch) begin
      value_q <= in_value_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_pos_q    <= cmd_i.res_pos_ptr ? bsws_pkg::pos_t'(ptr_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_from_rd ? bsws_pkg::STS_OK : res_status_q;
      out_data_q   <= cmd_i.out_from_rd ? rdata : '0;
      out_pos_q    <= cmd_i.out_from_rd ? '0 : res_pos_q;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    sts_o.empty     = (count_q == '0);
    sts_o.full      = (count_q == bsws_pkg::cnt_t'(bsws_pkg::DEPTH));
    sts_o.idx_ok    = (bsws_pkg::cmp_t'(in_index_i) < bsws_pkg::cmp_t'(count_q));
    sts_o.match     = (rdata == value_q);
    sts_o.scan_last = ((bsws_pkg::cnt_t'(ptr_q) + bsws_pkg::cnt_t'(1)) == count_q);
    sts_o.dump_last = (ptr_q == '0) || (n_q == bsws_pkg::LAST_N);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_data_o     = out_data_q;
  assign out_position_o = out_pos_q;
  assign out_last_o     = out_last_q;

endmodule

@@ hw/rtl/bsws_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: controller
// Decodes each request and sequences memory reads, the search scan, the
// dump walk and the loading of results.
// ----------------------------------------------------------------------------
module bsws_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [2:0]            in_cmd_i,
  output logic                  in_ready_o,
  input  bsws_pkg::dp_sts_t     sts_i,
  output bsws_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SCAN = 5'b00100,
    S_DUMP = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  bsws_pkg::cmd_e op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= bsws_pkg::CMD_PUSH;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.res_status = bsws_pkg::STS_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = bsws_pkg::cmd_e'(in_cmd_i);
          cmd_o.latch = 1'b1;
          case (bsws_pkg::cmd_e'(in_cmd_i))
            bsws_pkg::CMD_PUSH: begin
              cmd_o.res_set = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = bsws_pkg::STS_OVERFLOW;
              end else begin
                cmd_o.push_wr = 1'b1;
              end
              state_d = S_RESP;
            end
            bsws_pkg::CMD_POP, bsws_pkg::CMD_PEEK: begin
              if (sts_i.empty) begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = bsws_pkg::STS_EMPTY;
                state_d          = S_RESP;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_RD;
              end
            end
            bsws_pkg::CMD_FIND: begin
              if (sts_i.empty) begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = bsws_pkg::STS_NOT_FOUND;
                state_d          = S_RESP;
              end else begin
                cmd_o.rd_first = 1'b1;
                state_d        = S_SCAN;
              end
            end
            bsws_pkg::CMD_UPDATE: begin
              cmd_o.res_set = 1'b1;
              if (sts_i.idx_ok) begin
                cmd_o.upd_wr = 1'b1;
              end else begin
                cmd_o.res_status = bsws_pkg::STS_BAD_INDEX;
              end
              state_d = S_RESP;
            end
            bsws_pkg::CMD_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = bsws_pkg::STS_EMPTY;
                state_d          = S_RESP;
              end else begin
                cmd_o.rd_dump = 1'b1;
                state_d       = S_DUMP;
              end
            end
            default: begin
              // Unused codes are taken and dropped without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_from_rd = 1'b1;
          cmd_o.out_last    = 1'b1;
          cmd_o.pop_dec     = (op_q == bsws_pkg::CMD_POP);
          state_d           = S_IDLE;
        end
      end
      S_SCAN: begin
        // The memory output holds the entry at the scan pointer.
        if (sts_i.match) begin
          cmd_o.res_set     = 1'b1;
          cmd_o.res_pos_ptr = 1'b1;
          state_d           = S_RESP;
        end else if (sts_i.scan_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = bsws_pkg::STS_NOT_FOUND;
          state_d          = S_RESP;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_from_rd = 1'b1;
          cmd_o.out_last    = sts_i.dump_last;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.dump_next = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/bounded_stack_with_search_unit.sv @@
// ----------------------------------------------------------------------------
// Bounded stack with search: top level
// LIFO stack of signed 32-bit words with push, pop, peek, find, update and
// dump requests.
//
//   Channel  Dir  Handshake     Payload
//   in_i     in   valid/ready   cmd[2:0], value[31:0], index[2:0]
//   out_o    out  valid/ready   status[2:0], data[31:0], position[2:0], last
//
// Push and update load their result from S_RESP; pop and peek read the top
// entry and load it from S_RD. Find scans from the bottom up, then loads its
// result; dump emits one result per cycle while the output register is free.
// Requests are taken only between commands; a loaded result waits in the
// output register and stalls the next result, not the next acceptance.
// Reset empties the stack; entries are not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsws_in_if.sink     in_i,
  bsws_out_if.source  out_o
);

  bsws_pkg::ctrl_cmd_t cmd;
  bsws_pkg::dp_sts_t   sts;

  bsws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsws_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_value_i     (in_i.value),
    .in_index_i     (in_i.index),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_status_o   (out_o.status),
    .out_data_o     (out_o.data),
    .out_position_o (out_o.position),
    .out_last_o     (out_o.last)
  );

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  // The stack never grows past its depth or shrinks below empty.
  a_count_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push_wr |-> !sts.full) and (cmd.pop_dec |-> !sts.empty))
    else $error("stack count out of bounds");

  // No new request is taken in the middle of a dump.
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && !cmd.out_last) |=> !in_i.ready)
    else $error("request taken during a dump");

endmodule
